// File: rtl/core/sbh_pkg.sv
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types, constants and mixing functions of the selectable byte hash.
// ----------------------------------------------------------------------------
package sbh_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } item_type;

   typedef enum logic [1:0] {
      ALGO_SIP = 2'd0,
      ALGO_FNV = 2'd1,
      ALGO_MUR = 2'd2,
      ALGO_DJB = 2'd3
   } algo_type;

   localparam logic [1:0] CSR_HASH_SELECT = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW     = 2'd1;
   localparam logic [1:0] CSR_KEY_HIGH    = 2'd2;

   localparam logic [1:0]  HASH_SELECT_RESET = 2'd0;
   localparam logic [63:0] KEY_LOW_RESET     = 64'h74642d7865646f63;
   localparam logic [63:0] KEY_HIGH_RESET    = 64'h212179656b2d3831;

   localparam logic [31:0] FNV_OFFSET = 32'h811c9dc5;
   localparam logic [31:0] FNV_PRIME  = 32'h01000193;
   localparam logic [63:0] DJB_INIT   = 64'd5381;
   localparam logic [31:0] MUR_C1     = 32'hcc9e2d51;
   localparam logic [31:0] MUR_C2     = 32'h1b873593;
   localparam logic [31:0] MUR_ADD    = 32'he6546b64;
   localparam logic [31:0] MUR_F1     = 32'h85ebca6b;
   localparam logic [31:0] MUR_F2     = 32'hc2b2ae35;
   localparam logic [63:0] SIP_IV0    = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_IV1    = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_IV2    = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_IV3    = 64'h7465646279746573;

   typedef struct packed {
      logic [63:0] v0;
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] v3;
   } sip_state_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] p;
      p = a * b;
      return p;
   endfunction

   // First half of a SipRound: the two independent add-rotate-xor lanes.
   function automatic sip_state_type sip_half_a(input sip_state_type s);
      sip_state_type t;
      t = s;
      t.v0 = s.v0 + s.v1;
      t.v1 = rotl64(s.v1, 13) ^ t.v0;
      t.v0 = rotl64(t.v0, 32);
      t.v2 = s.v2 + s.v3;
      t.v3 = rotl64(s.v3, 16) ^ t.v2;
      return t;
   endfunction

   // Second half of a SipRound: the crossed lanes.
   function automatic sip_state_type sip_half_b(input sip_state_type s);
      sip_state_type t;
      t = s;
      t.v0 = s.v0 + s.v3;
      t.v3 = rotl64(s.v3, 21) ^ t.v0;
      t.v2 = s.v2 + s.v1;
      t.v1 = rotl64(s.v1, 17) ^ t.v2;
      t.v2 = rotl64(t.v2, 32);
      return t;
   endfunction

endpackage

// File: rtl/core/sbh_front.sv
// ----------------------------------------------------------------------------
// sbh_front
// Two-entry input queue that decouples the byte stream from the engine.
// ----------------------------------------------------------------------------
module sbh_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbh_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output sbh_pkg::item_type head_item,
   output logic              empty
);
   import sbh_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/sbh_engine.sv
// ----------------------------------------------------------------------------
// sbh_engine
// Sequencer that absorbs queued beats, runs the mixing steps and finishes.
// ----------------------------------------------------------------------------
module sbh_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        hash_select,
   input  logic [63:0]       key_low,
   input  logic [63:0]       key_high,
   input  logic              in_empty,
   input  sbh_pkg::item_type in_item,
   output logic              in_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [63:0]       rsp_hash_value
);
   import sbh_pkg::*;

   typedef enum logic [9:0] {
      S_TAKE = 10'b0000000001,
      S_SIP  = 10'b0000000010,
      S_MK1  = 10'b0000000100,
      S_MK2  = 10'b0000001000,
      S_MH   = 10'b0000010000,
      S_MF0  = 10'b0000100000,
      S_FMA  = 10'b0001000000,
      S_FMB  = 10'b0010000000,
      S_FMC  = 10'b0100000000,
      S_EMIT = 10'b1000000000
   } state_type;

   state_type     state_ff, state_in;
   sip_state_type v_ff, v_in;
   logic [63:0]   pb_ff, pb_in;
   logic [31:0]   cnt_ff, cnt_in;
   algo_type      algo_ff, algo_in;
   logic          active_ff, active_in;
   logic          last_ff, last_in;
   logic [63:0]   m_ff, m_in;
   logic [31:0]   mk_ff, mk_in;
   logic [3:0]    rnd_ff, rnd_in;
   logic          half_b_ff, half_b_in;
   logic          fin_ff, fin_in;
   logic          finr_ff, finr_in;
   logic          mur_fin_ff, mur_fin_in;
   logic [63:0]   hres_ff, hres_in;
   logic          out_valid_ff, out_valid_in;
   logic [63:0]   out_ff, out_in;

   always_comb begin
      algo_type      a_algo;
      sip_state_type b_v, n_v, t;
      logic [63:0]   b_pb, n_pb, fin;
      logic [31:0]   b_cnt, n_cnt, h;
      logic          vb;

      state_in     = state_ff;
      v_in         = v_ff;
      pb_in        = pb_ff;
      cnt_in       = cnt_ff;
      algo_in      = algo_ff;
      active_in    = active_ff;
      last_in      = last_ff;
      m_in         = m_ff;
      mk_in        = mk_ff;
      rnd_in       = rnd_ff;
      half_b_in    = half_b_ff;
      fin_in       = fin_ff;
      finr_in      = finr_ff;
      mur_fin_in   = mur_fin_ff;
      hres_in      = hres_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      in_pop       = 1'b0;
      a_algo       = algo_ff;
      b_v          = v_ff;
      b_pb         = pb_ff;
      b_cnt        = cnt_ff;
      n_v          = v_ff;
      n_pb         = pb_ff;
      n_cnt        = cnt_ff;
      t            = v_ff;
      fin          = '0;
      h            = '0;
      vb           = 1'b0;

      unique case (state_ff)
         S_TAKE: begin
            if (!in_empty) begin
               in_pop = 1'b1;
               if (!active_ff) begin
                  a_algo = algo_type'(hash_select);
                  b_pb   = '0;
                  b_cnt  = '0;
                  b_v    = '0;
                  unique case (a_algo)
                     ALGO_SIP: begin
                        b_v.v0 = SIP_IV0 ^ key_low;
                        b_v.v1 = SIP_IV1 ^ key_high;
                        b_v.v2 = SIP_IV2 ^ key_low;
                        b_v.v3 = SIP_IV3 ^ key_high;
                     end
                     ALGO_FNV: b_v.v0 = {32'd0, FNV_OFFSET};
                     ALGO_MUR: b_v.v0 = '0;
                     ALGO_DJB: b_v.v0 = DJB_INIT;
                     default:  b_v.v0 = '0;
                  endcase
               end
               vb    = in_item.byte_valid;
               n_v   = b_v;
               n_pb  = b_pb;
               n_cnt = b_cnt + {31'd0, vb};
               if (vb) begin
                  unique case (a_algo)
                     ALGO_SIP: n_pb = b_pb | ({56'd0, in_item.data_byte} << {b_cnt[2:0], 3'd0});
                     ALGO_FNV: n_v.v0 = {32'd0, mul32(b_v.v0[31:0] ^ {24'd0, in_item.data_byte},
                                                      FNV_PRIME)};
                     ALGO_MUR: n_pb = b_pb | ({56'd0, in_item.data_byte} << {b_cnt[1:0], 3'd0});
                     ALGO_DJB: n_v.v0 = (b_v.v0 << 5) + b_v.v0 + {56'd0, in_item.data_byte};
                     default:  n_v = b_v;
                  endcase
               end
               algo_in   = a_algo;
               active_in = 1'b1;
               last_in   = in_item.last;
               v_in      = n_v;
               pb_in     = n_pb;
               cnt_in    = n_cnt;
               rnd_in    = 4'd4;
               half_b_in = 1'b0;
               fin_in    = 1'b0;
               finr_in   = 1'b0;
               priority if (a_algo == ALGO_SIP && vb && b_cnt[2:0] == 3'd7) begin
                  v_in.v3  = n_v.v3 ^ n_pb;
                  m_in     = n_pb;
                  pb_in    = '0;
                  state_in = S_SIP;
               end else if (a_algo == ALGO_SIP && in_item.last) begin
                  fin      = n_pb | {n_cnt[7:0], 56'd0};
                  v_in.v3  = n_v.v3 ^ fin;
                  m_in     = fin;
                  fin_in   = 1'b1;
                  state_in = S_SIP;
               end else if (a_algo == ALGO_MUR && vb && b_cnt[1:0] == 2'd3) begin
                  mur_fin_in = 1'b0;
                  state_in   = S_MK1;
               end else if (a_algo == ALGO_MUR && in_item.last) begin
                  mur_fin_in = (n_cnt[1:0] != 2'd0);
                  state_in   = (n_cnt[1:0] != 2'd0) ? S_MK1 : S_MF0;
               end else if (in_item.last) begin
                  hres_in  = (a_algo == ALGO_FNV) ? {32'd0, n_v.v0[31:0]} : n_v.v0;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_TAKE;
               end
            end
         end
         S_SIP: begin
            t         = half_b_ff ? sip_half_b(v_ff) : sip_half_a(v_ff);
            rnd_in    = rnd_ff - 4'd1;
            half_b_in = !half_b_ff;
            if (rnd_ff == 4'd1) begin
               priority if (finr_ff) begin
                  hres_in  = t.v0 ^ t.v1 ^ t.v2 ^ t.v3;
                  finr_in  = 1'b0;
                  state_in = S_EMIT;
               end else if (fin_ff) begin
                  t.v0    = t.v0 ^ m_ff;
                  t.v2    = t.v2 ^ 64'h00000000000000ff;
                  rnd_in  = 4'd8;
                  fin_in  = 1'b0;
                  finr_in = 1'b1;
               end else if (last_ff) begin
                  t.v0   = t.v0 ^ m_ff;
                  fin    = pb_ff | {cnt_ff[7:0], 56'd0};
                  t.v3   = t.v3 ^ fin;
                  m_in   = fin;
                  rnd_in = 4'd4;
                  fin_in = 1'b1;
               end else begin
                  t.v0     = t.v0 ^ m_ff;
                  state_in = S_TAKE;
               end
            end
            v_in = t;
         end
         S_MK1: begin
            mk_in    = mul32(pb_ff[31:0], MUR_C1);
            state_in = S_MK2;
         end
         S_MK2: begin
            mk_in    = mul32(rotl32(mk_ff, 15), MUR_C2);
            state_in = mur_fin_ff ? S_MF0 : S_MH;
         end
         S_MH: begin
            h        = rotl32(v_ff.v0[31:0] ^ mk_ff, 13);
            v_in.v0  = {32'd0, mul32(h, 32'd5) + MUR_ADD};
            pb_in    = '0;
            state_in = last_ff ? S_MF0 : S_TAKE;
         end
         S_MF0: begin
            h        = v_ff.v0[31:0] ^ (mur_fin_ff ? mk_ff : 32'd0) ^ cnt_ff;
            v_in.v0  = {32'd0, h};
            state_in = S_FMA;
         end
         S_FMA: begin
            h        = v_ff.v0[31:0] ^ (v_ff.v0[31:0] >> 16);
            v_in.v0  = {32'd0, mul32(h, MUR_F1)};
            state_in = S_FMB;
         end
         S_FMB: begin
            h        = v_ff.v0[31:0] ^ (v_ff.v0[31:0] >> 13);
            v_in.v0  = {32'd0, mul32(h, MUR_F2)};
            state_in = S_FMC;
         end
         S_FMC: begin
            h        = v_ff.v0[31:0] ^ (v_ff.v0[31:0] >> 16);
            hres_in  = {32'd0, h};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_in       = hres_ff;
               out_valid_in = 1'b1;
               active_in    = 1'b0;
               state_in     = S_TAKE;
            end
         end
         default: state_in = S_TAKE;
      endcase
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_hash_value = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_TAKE;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         rnd_ff       <= 4'd0;
         half_b_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         finr_ff      <= 1'b0;
         mur_fin_ff   <= 1'b0;
         last_ff      <= 1'b0;
         algo_ff      <= ALGO_SIP;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         rnd_ff       <= rnd_in;
         half_b_ff    <= half_b_in;
         fin_ff       <= fin_in;
         finr_ff      <= finr_in;
         mur_fin_ff   <= mur_fin_in;
         last_ff      <= last_in;
         algo_ff      <= algo_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      pb_ff   <= pb_in;
      cnt_ff  <= cnt_in;
      m_ff    <= m_in;
      mk_ff   <= mk_in;
      hres_ff <= hres_in;
      out_ff  <= out_in;
   end

endmodule

// File: rtl/core/selectable_byte_hash.sv
// ----------------------------------------------------------------------------
// selectable_byte_hash
// Streaming byte hash with SipHash-2-4, FNV-1a, MurmurHash3 and djb2 modes.
// ----------------------------------------------------------------------------
// A message arrives with at most one byte per input beat, ends at the beat with
// last set, and yields one 64-bit result beat (32-bit hashes are zero-extended).
// The algorithm and SipHash key are sampled when a message starts. Beats enter
// a two-entry queue; a sequencer drains it one beat at a time. FNV-1a and djb2
// fold each byte in as its beat is taken. MurmurHash3 also runs, on each fourth
// byte, its two block multiplies and state update before it takes the next beat,
// and a tail scramble, if bytes remain, and the final mix to finish. SipHash also
// runs two SipRounds on each eighth byte (one half round per cycle), and to finish
// the length block and the finalization rounds. A result waits in an output
// register, so the next message is absorbed while it is unread; its result waits.
module selectable_byte_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_hash_value,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import sbh_pkg::*;

   logic [1:0]  hash_select_ff;
   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   item_type    push_item;
   item_type    head_item;
   logic        front_empty;
   logic        front_pop;

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_select_ff <= HASH_SELECT_RESET;
         key_low_ff     <= KEY_LOW_RESET;
         key_high_ff    <= KEY_HIGH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_HASH_SELECT: hash_select_ff <= csr_wdata[1:0];
            CSR_KEY_LOW:     key_low_ff     <= csr_wdata;
            CSR_KEY_HIGH:    key_high_ff    <= csr_wdata;
            default:         hash_select_ff <= hash_select_ff;
         endcase
      end
   end

   assign push_item.data_byte  = req_data_byte;
   assign push_item.byte_valid = req_byte_valid;
   assign push_item.last       = req_last;

   sbh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (push_item),
      .full      (req_full),
      .pop       (front_pop),
      .head_item (head_item),
      .empty     (front_empty)
   );

   sbh_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .hash_select    (hash_select_ff),
      .key_low        (key_low_ff),
      .key_high       (key_high_ff),
      .in_empty       (front_empty),
      .in_item        (head_item),
      .in_pop         (front_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_hash_value (rsp_hash_value)
   );

   // After reset neither the input queue nor the result register holds a beat.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full && front_empty))
      else $error("queues not empty after reset");

   // After an input beat is accepted, the input queue is not empty on the next cycle.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> !front_empty)
      else $error("accepted beat lost in input queue");

   // The engine only pops the input queue when it holds a beat.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      front_pop |-> !front_empty)
      else $error("engine popped an empty input queue");

endmodule

// File: tb/sv/selectable_byte_hash_checker.sv
// ----------------------------------------------------------------------------
// selectable_byte_hash_checker
// Watches the request, result and register ports, computes the expected hash
// of every message and compares each result beat with the oldest expectation.
// ----------------------------------------------------------------------------
module selectable_byte_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [63:0] rsp_hash_value,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sbh_pkg::*;

   logic [1:0]  sel_reg;
   logic [63:0] key_lo_reg;
   logic [63:0] key_hi_reg;
   logic [63:0] st [4];
   logic [63:0] part;
   logic [31:0] count;
   logic        in_msg;
   logic [1:0]  cur_algo;
   logic [63:0] hash_queue [$];

   assign pending_count = hash_queue.size();

   function automatic logic [63:0] rol64(logic [63:0] x, int n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic logic [31:0] rol32(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic sip_rnd();
      st[0] = st[0] + st[1]; st[1] = rol64(st[1], 13) ^ st[0]; st[0] = rol64(st[0], 32);
      st[2] = st[2] + st[3]; st[3] = rol64(st[3], 16) ^ st[2];
      st[0] = st[0] + st[3]; st[3] = rol64(st[3], 21) ^ st[0];
      st[2] = st[2] + st[1]; st[1] = rol64(st[1], 17) ^ st[2]; st[2] = rol64(st[2], 32);
   endtask

   task automatic sip_compress(logic [63:0] m);
      st[3] ^= m;
      sip_rnd();
      sip_rnd();
      st[0] ^= m;
   endtask

   function automatic logic [31:0] mur_scramble(logic [31:0] k);
      logic [31:0] t;
      t = k * 32'hcc9e2d51;
      t = rol32(t, 15);
      return t * 32'h1b873593;
   endfunction

   // Absorbs one request beat and returns 1 with the finished hash on last.
   task automatic absorb_beat(logic [7:0] b, logic v, logic l,
                              output logic done, output logic [63:0] hash);
      logic [31:0] h;
      int pos;
      done = 1'b0;
      hash = '0;
      if (!in_msg) begin
         cur_algo = sel_reg;
         part = '0;
         count = '0;
         for (int i = 0; i < 4; i++) st[i] = '0;
         case (algo_type'(cur_algo))
            ALGO_SIP: begin
               st[0] = 64'h736f6d6570736575 ^ key_lo_reg;
               st[1] = 64'h646f72616e646f6d ^ key_hi_reg;
               st[2] = 64'h6c7967656e657261 ^ key_lo_reg;
               st[3] = 64'h7465646279746573 ^ key_hi_reg;
            end
            ALGO_FNV: st[0] = 64'h811c9dc5;
            ALGO_DJB: st[0] = 64'd5381;
            default: ;
         endcase
         in_msg = 1'b1;
      end
      if (v) begin
         case (algo_type'(cur_algo))
            ALGO_SIP: begin
               pos = count[2:0];
               part |= 64'(b) << (pos * 8);
               if (pos == 7) begin
                  sip_compress(part);
                  part = '0;
               end
            end
            ALGO_FNV: st[0] = 64'(32'((st[0][31:0] ^ 32'(b)) * 32'h01000193));
            ALGO_MUR: begin
               pos = count[1:0];
               part |= 64'(b) << (pos * 8);
               if (pos == 3) begin
                  h = rol32(st[0][31:0] ^ mur_scramble(part[31:0]), 13);
                  st[0] = 64'(32'(h * 32'd5 + 32'he6546b64));
                  part = '0;
               end
            end
            default: st[0] = (st[0] << 5) + st[0] + 64'(b);
         endcase
         count = count + 32'd1;
      end
      if (l) begin
         case (algo_type'(cur_algo))
            ALGO_SIP: begin
               sip_compress(part | (64'(count[7:0]) << 56));
               st[2] ^= 64'hff;
               for (int i = 0; i < 4; i++) sip_rnd();
               hash = st[0] ^ st[1] ^ st[2] ^ st[3];
            end
            ALGO_FNV: hash = {32'd0, st[0][31:0]};
            ALGO_MUR: begin
               h = st[0][31:0];
               if (count[1:0] != 2'd0) h ^= mur_scramble(part[31:0]);
               h ^= count;
               h ^= h >> 16;
               h = h * 32'h85ebca6b;
               h ^= h >> 13;
               h = h * 32'hc2b2ae35;
               h ^= h >> 16;
               hash = {32'd0, h};
            end
            default: hash = st[0];
         endcase
         done = 1'b1;
         in_msg = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      logic done;
      logic [63:0] hash;
      if (reset) begin
         sel_reg = HASH_SELECT_RESET;
         key_lo_reg = KEY_LOW_RESET;
         key_hi_reg = KEY_HIGH_RESET;
         in_msg = 1'b0;
         cur_algo = '0;
         error_count = 0;
         hash_queue.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_HASH_SELECT: sel_reg = csr_wdata[1:0];
               CSR_KEY_LOW:     key_lo_reg = csr_wdata;
               CSR_KEY_HIGH:    key_hi_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (hash_queue.size() == 0) begin
               $error("unexpected result beat: hash_value actual %h", rsp_hash_value);
               error_count++;
            end else begin
               hash = hash_queue.pop_front();
               if (hash !== rsp_hash_value) begin
                  $error("hash_value mismatch: expected %h actual %h", hash, rsp_hash_value);
                  error_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            absorb_beat(req_data_byte, req_byte_valid, req_last, done, hash);
            if (done) hash_queue.push_back(hash);
         end
      end
   end

endmodule

// File: tb/sv/selectable_byte_hash_test.sv
// ----------------------------------------------------------------------------
// selectable_byte_hash_test
// Drives directed and random-byte messages through every hash mode and key setting,
// with random gaps on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module selectable_byte_hash_test;
   import sbh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The watchdog trips after this many cycles with no beat on any channel.
   localparam int IDLE_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        req_byte_valid;
   logic        req_last;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [63:0] rsp_hash_value;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;
   int          error_count;
   int          pending_count;
   int          idle_cycles;
   int          beats_sent;

   selectable_byte_hash dut (.*);

   selectable_byte_hash_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The result side pops each beat after a random wait, which may be none.
   // A wait is drawn when a beat is taken; once raised, pop stays high until a beat is taken.
   initial begin
      int wait_left;
      rsp_pop = 1'b0;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            wait_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end else if (wait_left > 0) begin
            wait_left--;
         end
         rsp_pop <= (wait_left == 0);
      end
   end

   // Counts cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(posedge clock);
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   task automatic write_reg(logic [1:0] idx, logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Sends one request beat after a gap, holding push until it is taken.
   // The gap is skipped for a stretch of the run so back-to-back beats occur.
   task automatic send_beat(logic [7:0] b, logic v, logic l, bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= b;
      req_byte_valid <= v;
      req_last <= l;
      do @(posedge clock); while (req_full);
      beats_sent++;
   endtask

   // Waits until the checker holds no expectation, then lets the block's
   // longest finishing pass go by so no beat is still being worked on.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // A message of len random bytes, with an occasional beat carrying no byte.
   task automatic send_message(int len, bit no_gaps);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b0, no_gaps);
         send_beat(8'($urandom), 1'b1, (i == len - 1), no_gaps);
      end
   endtask

   initial begin
      logic [63:0] keys_lo [4];
      logic [63:0] keys_hi [4];
      int len;
      reset = 1'b1;
      req_push = 1'b0;
      req_data_byte = '0;
      req_byte_valid = 1'b0;
      req_last = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_HASH_SELECT;
      csr_wdata = '0;
      beats_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset key: the empty message, a lone beat
      // with no byte before a last, extreme bytes and block boundaries.
      // Registers change only once every earlier message has finished.
      for (int a = 0; a < 4; a++) begin
         drain();
         write_reg(CSR_HASH_SELECT, 64'(a));
         send_beat(8'h00, 1'b0, 1'b1, 1'b0);
         send_beat(8'hff, 1'b0, 1'b0, 1'b0);
         send_beat(8'hff, 1'b1, 1'b1, 1'b0);
         send_beat(8'h00, 1'b1, 1'b1, 1'b0);
      end
      drain();
      write_reg(CSR_HASH_SELECT, 64'(ALGO_SIP));
      send_message(8, 1'b0);
      drain();
      write_reg(CSR_HASH_SELECT, 64'(ALGO_MUR));
      send_message(4, 1'b0);
      send_message(7, 1'b0);
      drain();

      // Key settings for the random part: all zeros, all ones, random and the reset key.
      keys_lo[0] = '0;          keys_hi[0] = '0;
      keys_lo[1] = '1;          keys_hi[1] = '1;
      keys_lo[2] = {$urandom, $urandom}; keys_hi[2] = {$urandom, $urandom};
      keys_lo[3] = KEY_LOW_RESET; keys_hi[3] = KEY_HIGH_RESET;

      for (int phase = 0; phase < 16; phase++) begin
         write_reg(CSR_KEY_LOW, keys_lo[phase % 4]);
         write_reg(CSR_KEY_HIGH, keys_hi[phase % 4]);
         write_reg(CSR_HASH_SELECT, 64'(phase / 4));
         while (beats_sent < 40 + (phase + 1) * 120) begin
            // Mostly short messages; now and then one past several blocks.
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(1, 12);
            send_message(len, phase == 5);
            if (phase == 9) begin
               // Hold off the sender until every result has come back.
               req_push <= 1'b0;
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
         end
         drain();
      end

      req_push <= 1'b0;
      drain();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/sbh_pkg.sv
rtl/core/sbh_front.sv
rtl/core/sbh_engine.sv
rtl/core/selectable_byte_hash.sv
tb/sv/selectable_byte_hash_checker.sv
tb/sv/selectable_byte_hash_test.sv
